### design/irst_pkg.sv
// irst_pkg: shared constants, types and helpers for the IMU rate/tilt core.
// No dependencies.
`default_nettype none
package irst_pkg;
  localparam int CordicSteps   = 16;
  localparam int AngleFracBits = 8;
  localparam int ZFrac         = 20;
  localparam int CW            = 40;  // cordic x/y width
  localparam int ZW            = 28;  // angle accumulator width
  localparam int SqW           = 48;  // radicand width
  localparam int RootW         = 24;
  localparam int RootSteps     = RootW;

  localparam logic [0:0] REG_GYRO  = 1'b0;
  localparam logic [0:0] REG_ACCEL = 1'b1;

  typedef struct packed {
    logic [1:0] gyro_range;
    logic [1:0] accel_range;
  } cfg_t;

  function automatic logic [ZW-1:0] atan_entry(input int i);
    logic [ZW-1:0] t;
    case (i)
      0: t = 28'd47185920;  1: t = 28'd27855475;  2: t = 28'd14718068;
      3: t = 28'd7471121;   4: t = 28'd3750058;   5: t = 28'd1876857;
      6: t = 28'd938658;    7: t = 28'd469357;    8: t = 28'd234682;
      9: t = 28'd117342;    10: t = 28'd58671;    11: t = 28'd29335;
      12: t = 28'd14668;    13: t = 28'd7334;     14: t = 28'd3667;
      15: t = 28'd1833;     16: t = 28'd917;      17: t = 28'd458;
      18: t = 28'd229;      19: t = 28'd115;      20: t = 28'd57;
      21: t = 28'd29;       22: t = 28'd14;       23: t = 28'd7;
      default: t = '0;
    endcase
    return t;
  endfunction
endpackage
`default_nettype wire

### design/irst_tilt.sv
// irst_tilt: pipelined atan2(c, sqrt(a^2+b^2)) in degrees: squares, a bit-per-stage
// integer square root, a CORDIC stage per step, rounding and clamp. Uses irst_pkg.
`default_nettype none
module irst_tilt (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [15:0] c_in,
  input  wire logic signed [15:0] a_in,
  input  wire logic signed [15:0] b_in,
  output logic signed [15:0]      angle
);
  localparam int CW = irst_pkg::CW;
  localparam int ZW = irst_pkg::ZW;
  localparam int NR = irst_pkg::RootSteps;
  localparam int NC = irst_pkg::CordicSteps;
  localparam int Sh = irst_pkg::ZFrac - irst_pkg::AngleFracBits;
  localparam int LimI = (90 << irst_pkg::AngleFracBits) > 32767 ? 32767
                        : (90 << irst_pkg::AngleFracBits);

  // stage 0: squares
  logic [31:0] sa, sb;
  logic signed [15:0] c0;
  always_ff @(posedge clk) begin
    if (en) begin
      sa <= 32'(unsigned'(32'(a_in * a_in)));
      sb <= 32'(unsigned'(32'(b_in * b_in)));
      c0 <= c_in;
    end
  end

  // square root: one result bit per stage
  localparam int RootW_ = irst_pkg::RootW;
  logic [irst_pkg::SqW-1:0] rn [0:NR];
  logic [RootW_-1:0]        rq [0:NR];
  logic signed [15:0]       rc [0:NR];
  always_ff @(posedge clk) begin
    if (en) begin
      rn[0] <= {15'd0, 33'(sa) + 33'(sb)} << 16;
      rq[0] <= '0;
      rc[0] <= c0;
    end
  end
  for (genvar k = 0; k < NR; k++) begin : g_root
    localparam int B = NR - 1 - k;
    logic [irst_pkg::SqW+1:0] trial;
    logic [irst_pkg::SqW+1:0] rem_hi;
    always_comb begin
      trial  = ({26'd0, rq[k]} << (B + 1)) | ((irst_pkg::SqW+2)'(1) << (2 * B));
      rem_hi = {2'b00, rn[k]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_hi >= trial) begin
          rn[k+1] <= rn[k] - irst_pkg::SqW'(trial);
          rq[k+1] <= rq[k] | (RootW_'(1) << B);
        end else begin
          rn[k+1] <= rn[k];
          rq[k+1] <= rq[k];
        end
        rc[k+1] <= rc[k];
      end
    end
  end

  // cordic
  logic signed [CW-1:0] cx [0:NC];
  logic signed [CW-1:0] cy [0:NC];
  logic signed [ZW-1:0] cz [0:NC];
  logic                 zr [0:NC];
  always_ff @(posedge clk) begin
    if (en) begin
      cx[0] <= CW'(signed'({1'b0, rq[NR]}));
      cy[0] <= CW'(rc[NR]) <<< 8;
      cz[0] <= '0;
      zr[0] <= (rq[NR] == '0) && (rc[NR] == '0);
    end
  end
  for (genvar i = 0; i < NC; i++) begin : g_cordic
    logic signed [ZW-1:0] t;
    assign t = signed'(irst_pkg::atan_entry(i));
    always_ff @(posedge clk) begin
      if (en) begin
        if (cy[i] > 0) begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + t;
        end else begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - t;
        end
        zr[i+1] <= zr[i];
      end
    end
  end

  // round half away from zero, clamp
  logic [ZW-1:0]        mag, q;
  logic signed [ZW-1:0] o;
  always_comb begin
    mag = cz[NC][ZW-1] ? ZW'(-cz[NC]) : ZW'(cz[NC]);
    q   = (mag + (ZW'(1) << (Sh - 1))) >> Sh;
    if (q > ZW'(LimI)) q = ZW'(LimI);
    o   = cz[NC][ZW-1] ? -signed'(q) : signed'(q);
  end
  always_ff @(posedge clk) begin
    if (en) angle <= zr[NC] ? 16'sd0 : 16'(o);
  end
endmodule
`default_nettype wire

### design/imu_rate_scale_and_tilt_core.sv
// imu_rate_scale_and_tilt_core: IMU sample to rates, g and tilt angles.
// Fully pipelined; one transaction per cycle while the pipeline advances.
// The pipeline advances whenever the output register is free or being taken.
// Reset (rst, synchronous) clears valid bits; gyro_range=1, accel_range=2.
// Depends on irst_pkg and irst_tilt.
`default_nettype none
module imu_rate_scale_and_tilt_core (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // gyro_x_raw, gyro_y_raw, gyro_z_raw, accel_x_raw, accel_y_raw, accel_z_raw
  input  wire logic [95:0]  s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // roll_rate, pitch_rate, yaw_rate, accel_x_g, accel_y_g, accel_z_g,
  // roll_angle, pitch_angle (143 bits, zero padded)
  output logic [143:0]      m_axis_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [0:0]   cfg_index,
  input  wire logic [1:0]   cfg_data
);
  localparam int Lat = irst_pkg::RootSteps + irst_pkg::CordicSteps + 4;

  irst_pkg::cfg_t cfg;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gyro_range  <= 2'd1;
      cfg.accel_range <= 2'd2;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        irst_pkg::REG_GYRO:  cfg.gyro_range  <= cfg_data;
        irst_pkg::REG_ACCEL: cfg.accel_range <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  logic [Lat-1:0] vld;
  assign en = !vld[Lat-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[Lat-1];
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[Lat-2:0], s_axis_tvalid};
  end

  logic signed [15:0] ax, ay, az;
  assign ax = s_axis_tdata[63:48];
  assign ay = s_axis_tdata[79:64];
  assign az = s_axis_tdata[95:80];

  // rates: stage 1 scale and add half divisor, stage 2 reciprocal multiply,
  // stage 3 correct and sign; then delay line
  logic [7:0] gmul, gdiv;
  always_comb begin
    case (cfg.gyro_range)
      2'd0: begin gmul = 8'd64;  gdiv = 8'd131; end
      2'd1: begin gmul = 8'd128; gdiv = 8'd131; end
      2'd2: begin gmul = 8'd80;  gdiv = 8'd41;  end
      default: begin gmul = 8'd160; gdiv = 8'd41; end
    endcase
  end

  logic [23:0] gm [0:2];   // |g|*mul + div/2
  logic        gs [0:2];
  logic [7:0]  gd;
  logic [16:0] gq [0:2];
  logic        gs2 [0:2];
  logic [23:0] gr1 [0:2];
  logic [7:0]  gd2;
  // floor(2^32 / div): estimate is the quotient or one below it
  logic [26:0] grecip;
  assign grecip = (gd == 8'd131) ? 27'd32786009 : 27'd104755299;
  for (genvar k = 0; k < 3; k++) begin : g_rate
    logic signed [15:0] g;
    logic [15:0] m;
    logic [50:0] prod;
    assign g = s_axis_tdata[16*k +: 16];
    assign m = g[15] ? 16'(-g) : 16'(g);
    always_ff @(posedge clk) begin
      if (en) begin
        gm[k] <= 24'(m) * 24'(gmul) + 24'(gdiv >> 1);
        gs[k] <= g[15];
      end
    end
    // divide by 131 or 41 via reciprocal, then one correction
    assign prod = 51'(gm[k]) * 51'(grecip);
    always_ff @(posedge clk) begin
      if (en) begin
        gq[k]  <= 17'(prod >> 32);
        gr1[k] <= gm[k];
        gs2[k] <= gs[k];
      end
    end
  end
  always_ff @(posedge clk) if (en) gd <= gdiv;
  always_ff @(posedge clk) if (en) gd2 <= gd;

  // exact quotient with small correction
  logic [17:0] rate [0:2];
  for (genvar k = 0; k < 3; k++) begin : g_fix
    logic [31:0] back, r;
    logic [16:0] qq;
    always_comb begin
      qq = gq[k];
      back = 32'(qq) * 32'(gd2);
      if (back > 32'(gr1[k])) begin
        qq = qq - 17'd1;
        back = back - 32'(gd2);
      end
      r = 32'(gr1[k]) - back;
      if (r >= 32'(gd2)) qq = qq + 17'd1;
    end
    always_ff @(posedge clk) if (en) rate[k] <= gs2[k] ? 18'(-signed'({1'b0, qq})) : 18'(qq);
  end

  logic [18:0] acc [0:2];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        acc[k] <= 19'(signed'(s_axis_tdata[16*k+48 +: 16])) <<< cfg.accel_range;
      end
    end
  end

  // delay lines to match tilt latency
  localparam int RD = Lat - 3;
  localparam int AD = Lat - 1;
  logic [53:0] rdl [0:RD-1];
  logic [56:0] adl [0:AD-1];
  always_ff @(posedge clk) begin
    if (en) begin
      rdl[0] <= {rate[2], rate[1], rate[0]};
      adl[0] <= {acc[2], acc[1], acc[0]};
      for (int i = 1; i < RD; i++) rdl[i] <= rdl[i-1];
      for (int i = 1; i < AD; i++) adl[i] <= adl[i-1];
    end
  end

  logic signed [15:0] roll, pit;
  irst_tilt u_roll (.clk, .en, .c_in(ay), .a_in(ax), .b_in(az), .angle(roll));
  irst_tilt u_pitch(.clk, .en, .c_in(ax), .a_in(ay), .b_in(az), .angle(pit));

  logic [15:0] pitn;
  assign pitn = 16'(-pit);
  assign m_axis_tdata = {1'b0, pitn, roll, adl[AD-1], rdl[RD-1]};
endmodule
`default_nettype wire
